// ----- sv/lmr_pkg.sv -----
`timescale 1ns / 1ps

package lmr_pkg;

    localparam int MAX_MEMBERS_DEF = 64;

    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_MODE    = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_RST = 7'd64;
    localparam logic [IDX_W-1:0] START_RST = 6'd0;

    localparam logic MODE_FIRST_LIVING = 1'b0;
    localparam logic MODE_NEXT_LIVING  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] first;
    } scan_ctrl_t;

    typedef struct packed {
        logic [IDX_W-1:0] cand;
        logic             last;
    } scan_stat_t;

endpackage

// ----- sv/lmr_scan.sv -----
`timescale 1ns / 1ps

// Candidate walker: one member per step, wraps at the member count,
// flags the final candidate of a full pass.
module lmr_scan
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lmr_pkg::scan_ctrl_t           ctrl,
    input  logic [lmr_pkg::CNT_W-1:0]     count,
    output lmr_pkg::scan_stat_t           stat
);

    logic [lmr_pkg::IDX_W-1:0] cand_reg;
    logic [lmr_pkg::IDX_W-1:0] cand_next;
    logic [lmr_pkg::CNT_W-1:0] left_reg;
    logic [lmr_pkg::CNT_W-1:0] left_next;
    logic [lmr_pkg::CNT_W-1:0] cand_inc;

    assign cand_inc = {1'b0, cand_reg} + lmr_pkg::CNT_W'(1);

    always_comb
    begin
        cand_next = cand_reg;
        left_next = left_reg;
        if (ctrl.load)
        begin
            cand_next = ctrl.first;
            left_next = count;
        end
        else if (ctrl.step)
        begin
            cand_next = (cand_inc == count) ? '0 : cand_inc[lmr_pkg::IDX_W-1:0];
            left_next = left_reg - lmr_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
            left_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            left_reg <= left_next;
        end
    end

    assign stat.cand = cand_reg;
    assign stat.last = (left_reg == lmr_pkg::CNT_W'(1));

endmodule

// ----- sv/living_member_reselector.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  member_index
// out       output     out_valid/out_stall selected_index, selection_changed,
//                                         none_alive, bad_index
// cfg       input      cfg_we             cfg_index, cfg_data
//
// An item that does not kill the selected member goes from idle to emit, and
// emit loads its result into the output register. Killing the selected member
// starts a search through the candidate walker, one member per cycle, until a
// living member is found or a full pass over member_count members finds none,
// and emit then loads that result into the output register.
// A new item is taken once the previous result is in the output register;
// while out_stall holds that register full, the next result waits in emit.
// Reset is asynchronous; the state is usable right after it, with no sweep.
module living_member_reselector
#(
    parameter int MAX_MEMBERS = lmr_pkg::MAX_MEMBERS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lmr_pkg::IDX_W-1:0]         member_index,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lmr_pkg::IDX_W-1:0]         selected_index,
    output logic                              selection_changed,
    output logic                              none_alive,
    output logic                              bad_index,

    input  logic                              cfg_we,
    input  logic [lmr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lmr_pkg::CFG_DAT_W-1:0]     cfg_data
);

    localparam int MASK_AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam logic [lmr_pkg::CNT_W-1:0] MAX_N = lmr_pkg::CNT_W'(MAX_MEMBERS);

    lmr_pkg::state_t state_reg;
    lmr_pkg::state_t state_next;

    logic [lmr_pkg::CNT_W-1:0] count_reg;
    logic [lmr_pkg::IDX_W-1:0] start_reg;
    logic                      mode_reg;

    logic [MAX_MEMBERS-1:0]    mask_reg;
    logic [MAX_MEMBERS-1:0]    mask_next;
    logic [lmr_pkg::IDX_W-1:0] sel_reg;
    logic [lmr_pkg::IDX_W-1:0] sel_next;

    logic res_changed_reg;
    logic res_changed_next;
    logic res_none_reg;
    logic res_none_next;
    logic res_bad_reg;
    logic res_bad_next;

    logic                      out_valid_reg;
    logic [lmr_pkg::IDX_W-1:0] out_sel_reg;
    logic                      out_changed_reg;
    logic                      out_none_reg;
    logic                      out_bad_reg;

    logic [lmr_pkg::CNT_W-1:0] n_eff;
    logic                      in_xfer;
    logic                      idx_bad;
    logic                      idx_hits_sel;
    logic                      cand_dead;
    logic                      emit_fire;
    logic [lmr_pkg::CNT_W-1:0] sel_inc;

    // config write: new register values and the selection they load
    logic [lmr_pkg::CNT_W-1:0] cfg_count;
    logic [lmr_pkg::IDX_W-1:0] cfg_start;
    logic [lmr_pkg::CNT_W-1:0] cfg_n;
    logic                      cfg_hit;

    lmr_pkg::scan_ctrl_t scan_ctrl;
    lmr_pkg::scan_stat_t scan_stat;

    lmr_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .count (n_eff),
        .stat  (scan_stat)
    );

    assign n_eff = (count_reg == '0) ? lmr_pkg::CNT_W'(1) :
                   (count_reg > MAX_N) ? MAX_N : count_reg;

    assign in_xfer      = in_valid && !in_stall;
    assign idx_bad      = ({1'b0, member_index} >= n_eff);
    assign idx_hits_sel = (member_index == sel_reg);
    assign cand_dead    = mask_reg[scan_stat.cand[MASK_AW-1:0]];
    assign sel_inc      = {1'b0, sel_reg} + lmr_pkg::CNT_W'(1);

    assign cfg_hit   = cfg_we && (cfg_index == lmr_pkg::CFG_MEMBER_COUNT ||
                                  cfg_index == lmr_pkg::CFG_START_INDEX ||
                                  cfg_index == lmr_pkg::CFG_PICK_MODE);
    assign cfg_count = (cfg_index == lmr_pkg::CFG_MEMBER_COUNT) ? cfg_data : count_reg;
    assign cfg_start = (cfg_index == lmr_pkg::CFG_START_INDEX) ?
                       cfg_data[lmr_pkg::IDX_W-1:0] : start_reg;
    assign cfg_n     = (cfg_count == '0) ? lmr_pkg::CNT_W'(1) :
                       (cfg_count > MAX_N) ? MAX_N : cfg_count;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!idx_bad && idx_hits_sel)
                        state_next = lmr_pkg::ST_SCAN;
                    else
                        state_next = lmr_pkg::ST_EMIT;
                end
            end
            lmr_pkg::ST_SCAN:
            begin
                if (!cand_dead || scan_stat.last)
                    state_next = lmr_pkg::ST_EMIT;
            end
            lmr_pkg::ST_EMIT:
            begin
                if (emit_fire)
                    state_next = lmr_pkg::ST_IDLE;
            end
            default:
                state_next = lmr_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_stall        = (state_reg != lmr_pkg::ST_IDLE);
        emit_fire       = (state_reg == lmr_pkg::ST_EMIT) && (!out_valid_reg || !out_stall);
        scan_ctrl.load  = (state_reg == lmr_pkg::ST_IDLE) && in_valid;
        scan_ctrl.step  = (state_reg == lmr_pkg::ST_SCAN) && cand_dead && !scan_stat.last;
        scan_ctrl.first = '0;
        if (mode_reg == lmr_pkg::MODE_NEXT_LIVING)
            scan_ctrl.first = (sel_inc == n_eff) ? '0 : sel_inc[lmr_pkg::IDX_W-1:0];
    end

    // selection, mask and pending result
    always_comb
    begin
        mask_next        = mask_reg;
        sel_next         = sel_reg;
        res_changed_next = res_changed_reg;
        res_none_next    = res_none_reg;
        res_bad_next     = res_bad_reg;
        if (cfg_hit)
        begin
            mask_next = '0;
            sel_next  = ({1'b0, cfg_start} < cfg_n) ? cfg_start :
                        lmr_pkg::IDX_W'(cfg_n - lmr_pkg::CNT_W'(1));
        end
        else if (in_xfer)
        begin
            res_changed_next = 1'b0;
            res_none_next    = 1'b0;
            res_bad_next     = idx_bad;
            if (!idx_bad)
                mask_next = mask_reg | (MAX_MEMBERS'(1) << member_index[MASK_AW-1:0]);
        end
        else if (state_reg == lmr_pkg::ST_SCAN)
        begin
            if (!cand_dead)
            begin
                sel_next         = scan_stat.cand;
                res_changed_next = 1'b1;
            end
            else if (scan_stat.last)
                res_none_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmr_pkg::ST_IDLE;
            count_reg     <= lmr_pkg::COUNT_RST;
            start_reg     <= lmr_pkg::START_RST;
            mode_reg      <= lmr_pkg::MODE_FIRST_LIVING;
            mask_reg      <= '0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            sel_reg   <= sel_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lmr_pkg::CFG_MEMBER_COUNT: count_reg <= cfg_data;
                    lmr_pkg::CFG_START_INDEX:  start_reg <= cfg_data[lmr_pkg::IDX_W-1:0];
                    lmr_pkg::CFG_PICK_MODE:    mode_reg  <= cfg_data[0];
                    default:                   ;
                endcase
            end
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_changed_reg <= res_changed_next;
        res_none_reg    <= res_none_next;
        res_bad_reg     <= res_bad_next;
        if (emit_fire)
        begin
            out_sel_reg     <= sel_reg;
            out_changed_reg <= res_changed_reg;
            out_none_reg    <= res_none_reg;
            out_bad_reg     <= res_bad_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign selected_index    = out_sel_reg;
    assign selection_changed = out_changed_reg;
    assign none_alive        = out_none_reg;
    assign bad_index         = out_bad_reg;

endmodule

// ----- dv/lmr_checker.sv -----
`timescale 1ns / 1ps

module lmr_checker
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [lmr_pkg::IDX_W-1:0]     member_index,

    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [lmr_pkg::IDX_W-1:0]     selected_index,
    input  logic                          selection_changed,
    input  logic                          none_alive,
    input  logic                          bad_index,

    input  logic                          cfg_we,
    input  logic [lmr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lmr_pkg::CFG_DAT_W-1:0] cfg_data,

    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [lmr_pkg::IDX_W-1:0] sel;
        logic                      changed;
        logic                      none;
        logic                      bad;
    } pick_t;

    // shadow of the block's registers and state
    logic [lmr_pkg::CNT_W-1:0]           count_q;
    logic [lmr_pkg::IDX_W-1:0]           start_q;
    logic                                mode_q;
    logic [lmr_pkg::MAX_MEMBERS_DEF-1:0] dead_q;
    logic [lmr_pkg::IDX_W-1:0]           sel_q;

    pick_t expected_picks[$];

    function automatic int live_count();
        if (count_q == 0)
            return 1;
        if (count_q > lmr_pkg::MAX_MEMBERS_DEF)
            return lmr_pkg::MAX_MEMBERS_DEF;
        return int'(count_q);
    endfunction

    function automatic void reload_roster();
        int n;
        n = live_count();
        dead_q = '0;
        sel_q = (int'(start_q) < n) ? start_q : lmr_pkg::IDX_W'(n - 1);
    endfunction

    function automatic pick_t mark_dead(input logic [lmr_pkg::IDX_W-1:0] idx);
        int n;
        int c;
        logic found;
        logic [lmr_pkg::IDX_W-1:0] pick;
        pick_t r;
        n = live_count();
        r = '0;
        found = 1'b0;
        pick = '0;
        if (int'(idx) >= n)
        begin
            r.bad = 1'b1;
        end
        else
        begin
            dead_q[idx] = 1'b1;
            if (idx == sel_q)
            begin
                if (mode_q == lmr_pkg::MODE_FIRST_LIVING)
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        if (!found && !dead_q[k])
                        begin
                            found = 1'b1;
                            pick = lmr_pkg::IDX_W'(k);
                        end
                    end
                end
                else
                begin
                    // circular walk starting after the current selection
                    for (int k = 1; k <= n; k++)
                    begin
                        c = (int'(sel_q) + k) % n;
                        if (!found && !dead_q[c])
                        begin
                            found = 1'b1;
                            pick = lmr_pkg::IDX_W'(c);
                        end
                    end
                end
                if (found)
                begin
                    sel_q = pick;
                    r.changed = 1'b1;
                end
                else
                begin
                    r.none = 1'b1;
                end
            end
        end
        r.sel = sel_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pick_t exp_r;
        if (!rst_n)
        begin
            count_q = lmr_pkg::COUNT_RST;
            start_q = lmr_pkg::START_RST;
            mode_q = lmr_pkg::MODE_FIRST_LIVING;
            dead_q = '0;
            sel_q = '0;
            expected_picks.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lmr_pkg::CFG_MEMBER_COUNT:
                    begin
                        count_q = cfg_data;
                        reload_roster();
                    end
                    lmr_pkg::CFG_START_INDEX:
                    begin
                        start_q = cfg_data[lmr_pkg::IDX_W-1:0];
                        reload_roster();
                    end
                    lmr_pkg::CFG_PICK_MODE:
                    begin
                        mode_q = cfg_data[0];
                        reload_roster();
                    end
                    default: ;
                endcase
            end
            // results first: a result in this cycle belongs to an earlier transfer
            if (out_valid && !out_stall)
            begin
                if (expected_picks.size() == 0)
                begin
                    $error("result transfer with nothing expected (selected_index %0d)",
                           selected_index);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_picks.pop_front();
                    if (selected_index !== exp_r.sel)
                    begin
                        $error("selected_index: expected %0d, got %0d",
                               exp_r.sel, selected_index);
                        fail_count++;
                    end
                    if (selection_changed !== exp_r.changed)
                    begin
                        $error("selection_changed: expected %0b, got %0b",
                               exp_r.changed, selection_changed);
                        fail_count++;
                    end
                    if (none_alive !== exp_r.none)
                    begin
                        $error("none_alive: expected %0b, got %0b",
                               exp_r.none, none_alive);
                        fail_count++;
                    end
                    if (bad_index !== exp_r.bad)
                    begin
                        $error("bad_index: expected %0b, got %0b",
                               exp_r.bad, bad_index);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_picks.push_back(mark_dead(member_index));
            pending = expected_picks.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam logic [lmr_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int ITEM_TARGET = 650;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [lmr_pkg::IDX_W-1:0]     member_index = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [lmr_pkg::IDX_W-1:0]     selected_index;
    logic                          selection_changed;
    logic                          none_alive;
    logic                          bad_index;
    logic                          cfg_we = 1'b0;
    logic [lmr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lmr_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    int  fail_count;
    int  pending;
    int  sent = 0;
    int  cur_count = 64;
    logic calm = 1'b0;

    living_member_reselector dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .member_index      (member_index),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .selected_index    (selected_index),
        .selection_changed (selection_changed),
        .none_alive        (none_alive),
        .bad_index         (bad_index),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    lmr_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .member_index      (member_index),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .selected_index    (selected_index),
        .selection_changed (selection_changed),
        .none_alive        (none_alive),
        .bad_index         (bad_index),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 26);
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int live_span(input int cnt);
        if (cnt == 0)
            return 1;
        if (cnt > lmr_pkg::MAX_MEMBERS_DEF)
            return lmr_pkg::MAX_MEMBERS_DEF;
        return cnt;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_member(input int idx);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        member_index = lmr_pkg::IDX_W'(idx);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // register writes only once every result is back
    task automatic write_reg(input logic [lmr_pkg::CFG_IDX_W-1:0] idx, input int data);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = lmr_pkg::CFG_DAT_W'(data);
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == lmr_pkg::CFG_MEMBER_COUNT)
            cur_count = data;
    endtask

    task automatic random_setup();
        int r;
        int cnt;
        r = $urandom_range(0, 99);
        if (r < 60)
            cnt = $urandom_range(1, 12);
        else if (r < 75)
            cnt = $urandom_range(13, 63);
        else if (r < 88)
            cnt = 64;
        else if (r < 94)
            cnt = 0;
        else
            cnt = $urandom_range(65, 127);
        if ($urandom_range(0, 99) < 30)
        begin
            // single register touched; others keep their values
            case ($urandom_range(0, 2))
                0: write_reg(lmr_pkg::CFG_MEMBER_COUNT, cnt);
                1: write_reg(lmr_pkg::CFG_START_INDEX, $urandom_range(0, 127));
                default: write_reg(lmr_pkg::CFG_PICK_MODE, $urandom_range(0, 127));
            endcase
        end
        else
        begin
            write_reg(lmr_pkg::CFG_MEMBER_COUNT, cnt);
            write_reg(lmr_pkg::CFG_START_INDEX, $urandom_range(0, 127));
            write_reg(lmr_pkg::CFG_PICK_MODE, $urandom_range(0, 127));
        end
    endtask

    task automatic random_phase();
        int n;
        int tmp;
        int j;
        int order[lmr_pkg::MAX_MEMBERS_DEF];
        n = live_span(cur_count);
        if ($urandom_range(0, 99) < 65)
        begin
            // kill every member in shuffled order, with some noise mixed in
            for (int i = 0; i < n; i++)
                order[i] = i;
            for (int i = n - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                    send_member($urandom_range(0, 63));
                send_member(order[i]);
            end
            // a few more after the roster is gone
            repeat ($urandom_range(0, 3))
                send_member($urandom_range(0, n - 1));
        end
        else
        begin
            repeat ($urandom_range(10, 30))
            begin
                if ($urandom_range(0, 99) < 85)
                    send_member($urandom_range(0, n - 1));
                else
                    send_member($urandom_range(0, 63));
            end
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: 64 members, first-living
        send_member(0);
        send_member(5);
        send_member(63);
        send_member(1);
        send_member(5);

        // zero count behaves as one member
        write_reg(lmr_pkg::CFG_MEMBER_COUNT, 0);
        send_member(0);
        send_member(0);
        send_member(1);
        send_member(63);

        // oversize count, start at the top, circular pick wraps to zero
        write_reg(lmr_pkg::CFG_MEMBER_COUNT, 127);
        write_reg(lmr_pkg::CFG_START_INDEX, 63);
        write_reg(lmr_pkg::CFG_PICK_MODE, lmr_pkg::MODE_NEXT_LIVING);
        send_member(63);
        send_member(0);

        // start index saturates to count-1
        write_reg(lmr_pkg::CFG_MEMBER_COUNT, 3);
        send_member(2);
        send_member(1);
        send_member(0);
        send_member(3);

        // spare register index must leave the roster alone
        write_reg(CFG_SPARE_INDEX, 127);
        send_member(0);
        send_member(2);

        write_reg(lmr_pkg::CFG_PICK_MODE, lmr_pkg::MODE_FIRST_LIVING);
        write_reg(lmr_pkg::CFG_MEMBER_COUNT, 64);
        write_reg(lmr_pkg::CFG_START_INDEX, 0);

        while (sent < ITEM_TARGET)
        begin
            calm = (sent >= 250 && sent < 400);
            random_setup();
            random_phase();
        end
        calm = 1'b0;
        in_valid = 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- living_member_reselector.f -----
sv/lmr_pkg.sv
sv/lmr_scan.sv
sv/living_member_reselector.sv
dv/lmr_checker.sv
dv/testbench.sv
